// ----- rtl/tstdp_pkg.sv -----
// tstdp_pkg: widths, register indexes, reset values and arithmetic helpers
// for the triplet stdp weight update block; no dependencies
package tstdp_pkg;

  // configurable datapath widths
  localparam int TRACE_W = 24;
  localparam int ACC_W   = 48;

  // fixed field widths
  localparam int DECAY_W = 16;
  localparam int AMP_W   = 24;
  localparam int FRAC    = 16;
  localparam int NUM_REGS = 8;
  localparam int IDX_W   = $clog2(NUM_REGS);
  localparam int CFG_W   = AMP_W;

  // shared multiplier shape: a is sized for the facilitation sum, b for a trace
  localparam int F_W    = AMP_W + TRACE_W - FRAC + 1;
  localparam int PROD_W = F_W + TRACE_W;
  localparam int RND_W  = PROD_W - FRAC;
  localparam int SUM_W  = ((ACC_W > RND_W) ? ACC_W : RND_W) + 2;

  // stream packing
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = ((ACC_W + 7) / 8) * 8;

  // register indexes
  localparam logic [IDX_W-1:0] REG_DECAY_PRE_FAST  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_DECAY_POST_FAST = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_DECAY_PRE_SLOW  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_DECAY_POST_SLOW = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_AMP_PAIR_PLUS   = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_AMP_PAIR_MINUS  = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_AMP_TRIP_PLUS   = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_AMP_TRIP_MINUS  = IDX_W'(7);

  // register reset values
  localparam logic [DECAY_W-1:0] RST_DECAY_PRE_FAST  = DECAY_W'(61723);
  localparam logic [DECAY_W-1:0] RST_DECAY_POST_FAST = DECAY_W'(63619);
  localparam logic [DECAY_W-1:0] RST_DECAY_PRE_SLOW  = DECAY_W'(64891);
  localparam logic [DECAY_W-1:0] RST_DECAY_POST_SLOW = DECAY_W'(65013);
  localparam logic [AMP_W-1:0]   RST_AMP_PAIR_PLUS   = AMP_W'(839);
  localparam logic [AMP_W-1:0]   RST_AMP_PAIR_MINUS  = AMP_W'(117441);
  localparam logic [AMP_W-1:0]   RST_AMP_TRIP_PLUS   = AMP_W'(104018);
  localparam logic [AMP_W-1:0]   RST_AMP_TRIP_MINUS  = AMP_W'(3859);

  // trace and accumulator limits
  localparam logic [TRACE_W-1:0] TRACE_MAX = {TRACE_W{1'b1}};
  localparam logic [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]   ACC_MIN   = ~ACC_MAX;
  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

  // configuration register set
  typedef struct packed {
    logic [DECAY_W-1:0] decay_pre_fast;
    logic [DECAY_W-1:0] decay_post_fast;
    logic [DECAY_W-1:0] decay_pre_slow;
    logic [DECAY_W-1:0] decay_post_slow;
    logic [AMP_W-1:0]   amp_pair_plus;
    logic [AMP_W-1:0]   amp_pair_minus;
    logic [AMP_W-1:0]   amp_trip_plus;
    logic [AMP_W-1:0]   amp_trip_minus;
  } cfg_regs_t;

  typedef struct packed {
    logic [TRACE_W-1:0] val;
    logic               sat;
  } trace_upd_t;

  typedef struct packed {
    logic [ACC_W-1:0] val;
    logic             sat;
  } acc_upd_t;

  // (p + half lsb) >> FRAC; products stay far below the carry-out point
  function automatic logic [RND_W-1:0] round_shift(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + PROD_W'(1 << (FRAC - 1));
    return s[PROD_W-1:FRAC];
  endfunction

  // add one spike to a trace, clamping at the trace maximum
  function automatic trace_upd_t trace_bump(input logic [TRACE_W-1:0] t,
                                            input logic spike);
    trace_upd_t r;
    logic [TRACE_W:0] s;
    s = {1'b0, t} + (TRACE_W+1)'(1 << FRAC);
    r.val = t;
    r.sat = 1'b0;
    if (spike) begin
      if (s[TRACE_W]) begin
        r.val = TRACE_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = s[TRACE_W-1:0];
      end
    end
    return r;
  endfunction

  // saturating accumulate of an unsigned magnitude, added or subtracted
  function automatic acc_upd_t acc_apply(input logic [ACC_W-1:0] acc,
                                         input logic [RND_W-1:0] mag,
                                         input logic do_it,
                                         input logic neg);
    acc_upd_t r;
    logic signed [SUM_W-1:0] a_ext;
    logic signed [SUM_W-1:0] d_ext;
    logic signed [SUM_W-1:0] s;
    a_ext = {{(SUM_W-ACC_W){acc[ACC_W-1]}}, acc};
    d_ext = {{(SUM_W-RND_W){1'b0}}, mag};
    s = neg ? (a_ext - d_ext) : (a_ext + d_ext);
    r.val = acc;
    r.sat = 1'b0;
    if (do_it) begin
      if (s > SUM_MAX) begin
        r.val = ACC_MAX;
        r.sat = 1'b1;
      end else if (s < SUM_MIN) begin
        r.val = ACC_MIN;
        r.sat = 1'b1;
      end else begin
        r.val = s[ACC_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/tstdp_cfg.sv -----
// tstdp_cfg: configuration register file written through the plain write port
// depends on tstdp_pkg
module tstdp_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tstdp_pkg::IDX_W-1:0] cfg_index,
  input  logic [tstdp_pkg::CFG_W-1:0] cfg_wdata,
  output tstdp_pkg::cfg_regs_t        regs
);

  tstdp_pkg::cfg_regs_t regs_r;
  tstdp_pkg::cfg_regs_t regs_nxt;

  // decode the write, keeping only each register's low bits
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        tstdp_pkg::REG_DECAY_PRE_FAST:
          regs_nxt.decay_pre_fast = cfg_wdata[tstdp_pkg::DECAY_W-1:0];
        tstdp_pkg::REG_DECAY_POST_FAST:
          regs_nxt.decay_post_fast = cfg_wdata[tstdp_pkg::DECAY_W-1:0];
        tstdp_pkg::REG_DECAY_PRE_SLOW:
          regs_nxt.decay_pre_slow = cfg_wdata[tstdp_pkg::DECAY_W-1:0];
        tstdp_pkg::REG_DECAY_POST_SLOW:
          regs_nxt.decay_post_slow = cfg_wdata[tstdp_pkg::DECAY_W-1:0];
        tstdp_pkg::REG_AMP_PAIR_PLUS:
          regs_nxt.amp_pair_plus = cfg_wdata[tstdp_pkg::AMP_W-1:0];
        tstdp_pkg::REG_AMP_PAIR_MINUS:
          regs_nxt.amp_pair_minus = cfg_wdata[tstdp_pkg::AMP_W-1:0];
        tstdp_pkg::REG_AMP_TRIP_PLUS:
          regs_nxt.amp_trip_plus = cfg_wdata[tstdp_pkg::AMP_W-1:0];
        tstdp_pkg::REG_AMP_TRIP_MINUS:
          regs_nxt.amp_trip_minus = cfg_wdata[tstdp_pkg::AMP_W-1:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.decay_pre_fast  <= tstdp_pkg::RST_DECAY_PRE_FAST;
      regs_r.decay_post_fast <= tstdp_pkg::RST_DECAY_POST_FAST;
      regs_r.decay_pre_slow  <= tstdp_pkg::RST_DECAY_PRE_SLOW;
      regs_r.decay_post_slow <= tstdp_pkg::RST_DECAY_POST_SLOW;
      regs_r.amp_pair_plus   <= tstdp_pkg::RST_AMP_PAIR_PLUS;
      regs_r.amp_pair_minus  <= tstdp_pkg::RST_AMP_PAIR_MINUS;
      regs_r.amp_trip_plus   <= tstdp_pkg::RST_AMP_TRIP_PLUS;
      regs_r.amp_trip_minus  <= tstdp_pkg::RST_AMP_TRIP_MINUS;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ----- rtl/tstdp_mul.sv -----
// tstdp_mul: shared unsigned multiplier with a registered product
// depends on tstdp_pkg
module tstdp_mul (
  input  logic                         clk,
  input  logic [tstdp_pkg::F_W-1:0]    op_a,
  input  logic [tstdp_pkg::TRACE_W-1:0] op_b,
  output logic [tstdp_pkg::PROD_W-1:0] prod
);

  logic [tstdp_pkg::PROD_W-1:0] prod_r;

  // one product per cycle, result available the cycle after
  always_ff @(posedge clk) begin
    prod_r <= tstdp_pkg::PROD_W'(op_a) * tstdp_pkg::PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

// ----- rtl/triplet_stdp_weight_update.sv -----
// triplet_stdp_weight_update: top level, tick sequencer and trace datapath
// depends on tstdp_pkg, tstdp_cfg, tstdp_mul
//
// One tick item enters per accept, and the block then runs nine sequencer
// steps through one shared multiplier (product registered): four trace
// decays, the two triplet products and the two pair products, with the
// rounded product of each step written back while the next one is formed.
// The next item is accepted only once the sequencer is idle again, after
// the final step, which waits until the output register is taken.
// The result register holds the accumulated weight change and the sticky
// saturation flag as they stand after the tick; a new tick is accepted while
// that result still waits. Configuration writes are taken at any time but
// should only be issued while no tick is in flight.
module triplet_stdp_weight_update (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [tstdp_pkg::IDX_W-1:0]      cfg_index,
  input  logic [tstdp_pkg::CFG_W-1:0]      cfg_wdata,
  // tick items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tstdp_pkg::IN_DATA_W-1:0]  in_tdata,   // pre_spike, post_spike, count_enable
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tstdp_pkg::OUT_DATA_W-1:0] out_tdata,  // weight_total
  output logic                             out_tuser   // saturated
);

  localparam int TW = tstdp_pkg::TRACE_W;
  localparam int AW = tstdp_pkg::ACC_W;
  localparam int FW = tstdp_pkg::F_W;

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8
  } state_t;

  tstdp_pkg::cfg_regs_t          regs;
  logic [FW-1:0]                 op_a;
  logic [TW-1:0]                 op_b;
  logic [tstdp_pkg::PROD_W-1:0]  prod;
  logic [tstdp_pkg::RND_W-1:0]   rnd;
  tstdp_pkg::trace_upd_t         bump_a;
  tstdp_pkg::trace_upd_t         bump_b;
  tstdp_pkg::acc_upd_t           acc_upd;
  logic                          out_free;

  state_t        state_r, state_nxt;
  logic          pre_r, pre_nxt;
  logic          post_r, post_nxt;
  logic          en_r, en_nxt;
  logic [TW-1:0] tpf_r, tpf_nxt;   // pre fast trace
  logic [TW-1:0] tqf_r, tqf_nxt;   // post fast trace
  logic [TW-1:0] tps_r, tps_nxt;   // pre slow trace
  logic [TW-1:0] tqs_r, tqs_nxt;   // post slow trace
  logic [FW-1:0] f_r, f_nxt;       // facilitation sum
  logic [AW-1:0] acc_r, acc_nxt;
  logic          sat_r, sat_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_data_r, out_data_nxt;
  logic          out_sat_r, out_sat_nxt;

  tstdp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  tstdp_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign rnd       = tstdp_pkg::round_shift(prod);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // multiplier operand selection per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_M0: begin
        op_a = FW'(tpf_r);
        op_b = TW'(regs.decay_pre_fast);
      end
      S_M1: begin
        op_a = FW'(tqf_r);
        op_b = TW'(regs.decay_post_fast);
      end
      S_M2: begin
        op_a = FW'(tps_r);
        op_b = TW'(regs.decay_pre_slow);
      end
      S_M3: begin
        op_a = FW'(tqs_r);
        op_b = TW'(regs.decay_post_slow);
      end
      S_M4: begin
        op_a = FW'(regs.amp_trip_minus);
        op_b = tps_r;
      end
      S_M5: begin
        op_a = FW'(regs.amp_trip_plus);
        op_b = tqs_r;
      end
      S_M6: begin
        op_a = f_r;
        op_b = tqf_r;
      end
      // potentiation product, held while the last step waits
      S_M7, S_M8: begin
        op_a = f_r;
        op_b = tpf_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // spike bumps and accumulator update, chosen per step
  always_comb begin
    bump_a  = tstdp_pkg::trace_bump(rnd[TW-1:0], 1'b0);
    bump_b  = tstdp_pkg::trace_bump(tqs_r, 1'b0);
    acc_upd = tstdp_pkg::acc_apply(acc_r, rnd, 1'b0, 1'b0);
    case (state_r)
      S_M1: bump_a = tstdp_pkg::trace_bump(rnd[TW-1:0], pre_r);
      S_M2: bump_a = tstdp_pkg::trace_bump(rnd[TW-1:0], post_r);
      S_M7: acc_upd = tstdp_pkg::acc_apply(acc_r, rnd, en_r && pre_r, 1'b1);
      S_M8: begin
        bump_a  = tstdp_pkg::trace_bump(tps_r, pre_r);
        bump_b  = tstdp_pkg::trace_bump(tqs_r, post_r);
        acc_upd = tstdp_pkg::acc_apply(acc_r, rnd, en_r && post_r, 1'b0);
      end
      default: begin
        bump_a  = tstdp_pkg::trace_bump(rnd[TW-1:0], 1'b0);
        bump_b  = tstdp_pkg::trace_bump(tqs_r, 1'b0);
        acc_upd = tstdp_pkg::acc_apply(acc_r, rnd, 1'b0, 1'b0);
      end
    endcase
  end

  // tick sequencer
  always_comb begin
    state_nxt     = state_r;
    pre_nxt       = pre_r;
    post_nxt      = post_r;
    en_nxt        = en_r;
    tpf_nxt       = tpf_r;
    tqf_nxt       = tqf_r;
    tps_nxt       = tps_r;
    tqs_nxt       = tqs_r;
    f_nxt         = f_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          pre_nxt   = in_tdata[0];
          post_nxt  = in_tdata[1];
          en_nxt    = in_tdata[2];
          state_nxt = S_M0;
        end
      end
      S_M0: state_nxt = S_M1;
      S_M1: begin
        tpf_nxt   = bump_a.val;
        sat_nxt   = sat_r | bump_a.sat;
        state_nxt = S_M2;
      end
      S_M2: begin
        tqf_nxt   = bump_a.val;
        sat_nxt   = sat_r | bump_a.sat;
        state_nxt = S_M3;
      end
      S_M3: begin
        tps_nxt   = rnd[TW-1:0];
        state_nxt = S_M4;
      end
      S_M4: begin
        tqs_nxt   = rnd[TW-1:0];
        state_nxt = S_M5;
      end
      S_M5: begin
        f_nxt     = FW'(regs.amp_pair_minus) + rnd[FW-1:0];
        state_nxt = S_M6;
      end
      S_M6: begin
        f_nxt     = FW'(regs.amp_pair_plus) + rnd[FW-1:0];
        state_nxt = S_M7;
      end
      S_M7: begin
        acc_nxt   = acc_upd.val;
        sat_nxt   = sat_r | acc_upd.sat;
        state_nxt = S_M8;
      end
      S_M8: begin
        // the last step waits here until the result register is free
        if (out_free) begin
          acc_nxt       = acc_upd.val;
          tps_nxt       = bump_a.val;
          tqs_nxt       = bump_b.val;
          sat_nxt       = sat_r | acc_upd.sat | bump_a.sat | bump_b.sat;
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_upd.val;
          out_sat_nxt   = sat_r | acc_upd.sat | bump_a.sat | bump_b.sat;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tpf_r       <= '0;
      tqf_r       <= '0;
      tps_r       <= '0;
      tqs_r       <= '0;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tpf_r       <= tpf_nxt;
      tqf_r       <= tqf_nxt;
      tps_r       <= tps_nxt;
      tqs_r       <= tqs_nxt;
      acc_r       <= acc_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pre_r      <= pre_nxt;
    post_r     <= post_nxt;
    en_r       <= en_nxt;
    f_r        <= f_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tstdp_pkg::OUT_DATA_W'(out_data_r);
  assign out_tuser  = out_sat_r;

endmodule
